### rtl/core/prrt_pkg.sv
// ----------------------------------------------------------------------------
// prrt_pkg
// Shared types, codes and saturation helper for the position table.
// ----------------------------------------------------------------------------
package prrt_pkg;

   localparam int NUM_INSTRUMENTS_DEFAULT = 256;
   localparam int COUNT_WIDTH = 32;
   localparam int INST_W      = 8;
   localparam int VOL_W       = 31;
   localparam int SIDE_W      = 3;
   localparam int OP_W        = 3;

   localparam logic [OP_W-1:0] OP_RESERVE = 3'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
   localparam logic [OP_W-1:0] OP_TRADE   = 3'd2;
   localparam logic [OP_W-1:0] OP_LOAD    = 3'd3;

   localparam logic [SIDE_W-1:0] SIDE_BUY              = 3'd0;
   localparam logic [SIDE_W-1:0] SIDE_SELL             = 3'd1;
   localparam logic [SIDE_W-1:0] SIDE_BUY_COVER        = 3'd2;
   localparam logic [SIDE_W-1:0] SIDE_BUY_COVER_TODAY  = 3'd3;
   localparam logic [SIDE_W-1:0] SIDE_BUY_COVER_YEST   = 3'd4;
   localparam logic [SIDE_W-1:0] SIDE_SELL_COVER       = 3'd5;
   localparam logic [SIDE_W-1:0] SIDE_SELL_COVER_TODAY = 3'd6;
   localparam logic [SIDE_W-1:0] SIDE_SELL_COVER_YEST  = 3'd7;

   typedef logic signed [COUNT_WIDTH-1:0] count_type;
   typedef logic signed [COUNT_WIDTH+1:0] wide_type;
   typedef logic signed [COUNT_WIDTH:0]   net_type;

   localparam wide_type CNT_MAX = {3'b000, {(COUNT_WIDTH-1){1'b1}}};
   localparam wide_type CNT_MIN = {3'b111, {(COUNT_WIDTH-1){1'b0}}};

   typedef struct packed {
      count_type ll;
      count_type ls;
      count_type tl;
      count_type ts;
      count_type yl;
      count_type ys;
   } entry_type;

   typedef enum logic [2:0] {
      KIND_RESERVE,
      KIND_RELEASE,
      KIND_TRADE,
      KIND_LOAD,
      KIND_QUERY,
      KIND_SKIP
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [INST_W-1:0] instrument;
      logic [SIDE_W-1:0] side;
      logic              bid;
      logic              yest;
      logic [VOL_W-1:0]  amount;
      entry_type         load;
   } item_type;

   function automatic count_type sat(input wide_type v);
      if (v > CNT_MAX) begin
         return CNT_MAX[COUNT_WIDTH-1:0];
      end else if (v < CNT_MIN) begin
         return CNT_MIN[COUNT_WIDTH-1:0];
      end
      return v[COUNT_WIDTH-1:0];
   endfunction

endpackage

### rtl/core/prrt_front.sv
// ----------------------------------------------------------------------------
// prrt_front
// Accepts requests and classifies them into work items for the queue.
// ----------------------------------------------------------------------------
module prrt_front #(
   parameter int NUM_INSTRUMENTS = prrt_pkg::NUM_INSTRUMENTS_DEFAULT
) (
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [prrt_pkg::OP_W-1:0]         req_op,
   input  logic [prrt_pkg::INST_W-1:0]       req_instrument,
   input  logic [prrt_pkg::SIDE_W-1:0]       req_side,
   input  logic [prrt_pkg::VOL_W-1:0]        req_volume,
   input  logic [prrt_pkg::VOL_W-1:0]        req_executed_volume,
   input  logic                              req_order_open,
   input  prrt_pkg::entry_type               req_load,
   input  logic                              q_full,
   output logic                              q_push,
   output prrt_pkg::item_type                q_item
);
   import prrt_pkg::*;

   logic in_range;
   logic bid;
   logic release_ok;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   assign in_range = 32'(req_instrument) < NUM_INSTRUMENTS;
   assign bid = (req_side == SIDE_BUY) || (req_side == SIDE_BUY_COVER) ||
                (req_side == SIDE_BUY_COVER_TODAY) || (req_side == SIDE_BUY_COVER_YEST);
   assign release_ok = !req_order_open && (req_executed_volume < req_volume) &&
                       (req_side != SIDE_BUY) && (req_side != SIDE_SELL);

   always_comb begin
      q_item            = '0;
      q_item.instrument = req_instrument;
      q_item.side       = req_side;
      q_item.bid        = bid;
      q_item.yest       = (req_side == SIDE_BUY_COVER_YEST) ||
                          (req_side == SIDE_SELL_COVER_YEST);
      q_item.amount     = req_volume;
      q_item.load       = req_load;
      unique case (req_op)
         OP_RESERVE: q_item.kind = KIND_RESERVE;
         OP_RELEASE: begin
            // an inapplicable release behaves like a query
            q_item.kind   = release_ok ? KIND_RELEASE : KIND_QUERY;
            q_item.amount = req_volume - req_executed_volume;
         end
         OP_TRADE:   q_item.kind = KIND_TRADE;
         OP_LOAD:    q_item.kind = KIND_LOAD;
         default:    q_item.kind = KIND_QUERY;
      endcase
      if (!in_range) begin
         q_item.kind = KIND_SKIP;
      end
   end

endmodule

### rtl/core/prrt_queue.sv
// ----------------------------------------------------------------------------
// prrt_queue
// Two-entry queue between the classifier and the execution stage.
// ----------------------------------------------------------------------------
module prrt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  prrt_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output prrt_pkg::item_type head
);
   import prrt_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/prrt_back.sv
// ----------------------------------------------------------------------------
// prrt_back
// Table memory, read-modify-write execution and the response register.
// ----------------------------------------------------------------------------
module prrt_back #(
   parameter int NUM_INSTRUMENTS = prrt_pkg::NUM_INSTRUMENTS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic                        csr_write_data,
   input  logic                        q_empty,
   input  prrt_pkg::item_type          q_head,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_accepted,
   output logic [prrt_pkg::SIDE_W-1:0] rsp_assigned_side,
   output prrt_pkg::net_type           rsp_net_position,
   output logic                        rsp_updated,
   output prrt_pkg::entry_type         rsp_entry
);
   import prrt_pkg::*;

   localparam int IDX_W = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic               split_mode_ff;
   item_type           item_ff;
   entry_type          rd_ff;
   entry_type          mem [NUM_INSTRUMENTS];

   logic [INST_W+IDX_W-1:0] rd_ext, wr_ext;
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic               wr_en;
   entry_type          wr_data;
   logic               slot_free, fire;

   entry_type          nxt;
   logic               acc;
   logic [SIDE_W-1:0]  asg;
   wide_type           vol, liq, yst;
   count_type          nliq, nyst;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_acc_ff;
   logic [SIDE_W-1:0]  rsp_asg_ff;
   net_type            rsp_net_ff;
   entry_type          rsp_entry_ff;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign fire      = (state_ff == ST_EXEC) && slot_free;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;

   assign rd_ext  = {{IDX_W{1'b0}}, q_head.instrument};
   assign rd_addr = rd_ext[IDX_W-1:0];
   assign wr_ext  = {{IDX_W{1'b0}}, item_ff.instrument};

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == IDX_W'(NUM_INSTRUMENTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // per-operation update of the entry read from the table
   always_comb begin
      nxt  = rd_ff;
      acc  = 1'b0;
      asg  = item_ff.side;
      vol  = wide_type'(item_ff.amount);
      liq  = item_ff.bid ? wide_type'(rd_ff.ls) : wide_type'(rd_ff.ll);
      yst  = item_ff.bid ? wide_type'(rd_ff.ys) : wide_type'(rd_ff.yl);
      nliq = liq[COUNT_WIDTH-1:0];
      nyst = yst[COUNT_WIDTH-1:0];
      case (item_ff.kind)
         KIND_RESERVE: begin
            if (split_mode_ff) begin
               if (vol <= yst) begin
                  nliq = sat(liq - vol);
                  nyst = sat(yst - vol);
                  asg  = item_ff.bid ? SIDE_BUY_COVER_YEST : SIDE_SELL_COVER_YEST;
                  acc  = 1'b1;
               end else if (vol + yst <= liq) begin
                  nliq = sat(liq - vol);
                  asg  = item_ff.bid ? SIDE_BUY_COVER_TODAY : SIDE_SELL_COVER_TODAY;
                  acc  = 1'b1;
               end
            end else if (vol <= liq) begin
               nliq = sat(liq - vol);
               asg  = item_ff.bid ? SIDE_BUY_COVER : SIDE_SELL_COVER;
               acc  = 1'b1;
            end
            if (item_ff.bid) begin
               nxt.ls = nliq;
               nxt.ys = nyst;
            end else begin
               nxt.ll = nliq;
               nxt.yl = nyst;
            end
         end
         KIND_RELEASE: begin
            acc = 1'b1;
            if (item_ff.bid) begin
               nxt.ls = sat(wide_type'(rd_ff.ls) + vol);
               if (item_ff.yest) nxt.ys = sat(wide_type'(rd_ff.ys) + vol);
            end else begin
               nxt.ll = sat(wide_type'(rd_ff.ll) + vol);
               if (item_ff.yest) nxt.yl = sat(wide_type'(rd_ff.yl) + vol);
            end
         end
         KIND_TRADE: begin
            acc = 1'b1;
            if (item_ff.side == SIDE_BUY) begin
               nxt.ll = sat(wide_type'(rd_ff.ll) + vol);
               nxt.tl = sat(wide_type'(rd_ff.tl) + vol);
            end else if (item_ff.side == SIDE_SELL) begin
               nxt.ls = sat(wide_type'(rd_ff.ls) + vol);
               nxt.ts = sat(wide_type'(rd_ff.ts) + vol);
            end else if (item_ff.bid) begin
               nxt.ts = sat(wide_type'(rd_ff.ts) - vol);
            end else begin
               nxt.tl = sat(wide_type'(rd_ff.tl) - vol);
            end
         end
         KIND_LOAD: begin
            acc = 1'b1;
            nxt = item_ff.load;
         end
         default: ;
      endcase
   end

   always_comb begin
      wr_en   = (state_ff == ST_CLEAR) || (fire && acc);
      wr_addr = (state_ff == ST_CLEAR) ? clr_cnt_ff : wr_ext[IDX_W-1:0];
      wr_data = (state_ff == ST_CLEAR) ? '0 : nxt;
   end

   // the entry read at pop is held while the response slot is busy
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (q_pop) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         split_mode_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) split_mode_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_head;
      end
      if (fire) begin
         rsp_asg_ff <= asg;
         if (item_ff.kind == KIND_SKIP) begin
            rsp_acc_ff   <= 1'b0;
            rsp_net_ff   <= '0;
            rsp_entry_ff <= '0;
         end else begin
            rsp_acc_ff   <= acc;
            rsp_net_ff   <= net_type'(wide_type'(nxt.tl) - wide_type'(nxt.ts));
            rsp_entry_ff <= nxt;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_updated       = rsp_acc_ff;
   assign rsp_assigned_side = rsp_asg_ff;
   assign rsp_net_position  = rsp_net_ff;
   assign rsp_entry         = rsp_entry_ff;

endmodule

### rtl/core/position_reserve_release_table.sv
// ----------------------------------------------------------------------------
// position_reserve_release_table
// Per-instrument position table with reserve, release, trade, load, query.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel (valid/stall) and each produces exactly
// one response on the rsp_ channel, in order. A front stage classifies each
// request and pushes it into a two-entry queue; the back stage pops one item,
// reads the instrument's entry from the table memory, updates and writes it
// back, and loads the response register.
// A request passes the queue slot, the item and entry registers and the
// response register. The back stage takes one item at a time: it reads the
// entry at pop, writes it back on execution and only then pops the next.
// After reset the back stage clears the table, one entry a cycle, through
// all NUM_INSTRUMENTS entries; requests are queued (two) but not executed
// until the pass ends. csr_write_enable sets the split mode at any time.
// When rsp_stall is high the response holds, the back stage waits and the
// queue fills; req_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module position_reserve_release_table #(
   parameter int NUM_INSTRUMENTS = prrt_pkg::NUM_INSTRUMENTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic                               csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [prrt_pkg::OP_W-1:0]          req_op,
   input  logic [prrt_pkg::INST_W-1:0]        req_instrument,
   input  logic [prrt_pkg::SIDE_W-1:0]        req_side,
   input  logic [prrt_pkg::VOL_W-1:0]         req_volume,
   input  logic [prrt_pkg::VOL_W-1:0]         req_executed_volume,
   input  logic                               req_order_open,
   input  prrt_pkg::count_type                req_load_liquid_long,
   input  prrt_pkg::count_type                req_load_liquid_short,
   input  prrt_pkg::count_type                req_load_total_long,
   input  prrt_pkg::count_type                req_load_total_short,
   input  prrt_pkg::count_type                req_load_yest_long,
   input  prrt_pkg::count_type                req_load_yest_short,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_accepted,
   output logic [prrt_pkg::SIDE_W-1:0]        rsp_assigned_side,
   output prrt_pkg::net_type                  rsp_net_position,
   output logic                               rsp_updated,
   output prrt_pkg::count_type                rsp_liquid_long,
   output prrt_pkg::count_type                rsp_liquid_short,
   output prrt_pkg::count_type                rsp_total_long,
   output prrt_pkg::count_type                rsp_total_short,
   output prrt_pkg::count_type                rsp_yest_long,
   output prrt_pkg::count_type                rsp_yest_short
);
   import prrt_pkg::*;

   entry_type load_entry;
   entry_type out_entry;
   item_type  push_item;
   item_type  head_item;
   logic      q_full, q_empty, q_push, q_pop;

   always_comb begin
      load_entry.ll = req_load_liquid_long;
      load_entry.ls = req_load_liquid_short;
      load_entry.tl = req_load_total_long;
      load_entry.ts = req_load_total_short;
      load_entry.yl = req_load_yest_long;
      load_entry.ys = req_load_yest_short;
   end

   prrt_front #(.NUM_INSTRUMENTS(NUM_INSTRUMENTS)) u_front (
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_instrument      (req_instrument),
      .req_side            (req_side),
      .req_volume          (req_volume),
      .req_executed_volume (req_executed_volume),
      .req_order_open      (req_order_open),
      .req_load            (load_entry),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_item              (push_item)
   );

   prrt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (head_item)
   );

   prrt_back #(.NUM_INSTRUMENTS(NUM_INSTRUMENTS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .q_empty           (q_empty),
      .q_head            (head_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_assigned_side (rsp_assigned_side),
      .rsp_net_position  (rsp_net_position),
      .rsp_updated       (rsp_updated),
      .rsp_entry         (out_entry)
   );

   assign rsp_liquid_long  = out_entry.ll;
   assign rsp_liquid_short = out_entry.ls;
   assign rsp_total_long   = out_entry.tl;
   assign rsp_total_short  = out_entry.ts;
   assign rsp_yest_long    = out_entry.yl;
   assign rsp_yest_short   = out_entry.ys;

   a_upd_matches_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_updated == rsp_accepted))
      else $error("updated differs from accepted");

   a_net_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_net_position ==
         net_type'(wide_type'(rsp_total_long) - wide_type'(rsp_total_short))))
      else $error("net position does not match totals");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

endmodule
